[sv/vpw_pkg.sv]
package vpw_pkg;

   localparam int WORD_W = 32;
   localparam int LANES  = 3;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [3:0][WORD_W-1:0] vec_type;
   typedef logic [15:0][WORD_W-1:0] mat_type;

   typedef enum logic [1:0] {
      CMD_LOAD_MODEL = 2'd0,
      CMD_LOAD_PROJ  = 2'd1,
      CMD_PROJECT    = 2'd2
   } cmd_type;

   localparam logic [1:0] REG_VP_X      = 2'd0;
   localparam logic [1:0] REG_VP_Y      = 2'd1;
   localparam logic [1:0] REG_VP_WIDTH  = 2'd2;
   localparam logic [1:0] REG_VP_HEIGHT = 2'd3;

   // side info that travels with a point through the divider
   typedef struct packed {
      logic             vld;
      logic             zero_w;
      logic [LANES-1:0] neg;
   } side_type;

endpackage

[sv/vpw_xform.sv]
module vpw_xform #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             en,
   input  vpw_pkg::vec_type vec_in,
   input  vpw_pkg::mat_type mat,
   output vpw_pkg::vec_type vec_out
);

   localparam int TW = 64 - FRAC_BITS;
   localparam int AW = TW + 2;
   localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [AW-1:0] SMAX = AW'(64'sd2147483647);
   localparam logic signed [AW-1:0] SMIN = AW'(-64'sd2147483648);

   logic signed [TW-1:0] term_in [16];
   logic signed [TW-1:0] term_ff [16];
   vpw_pkg::vec_type     sum_in;
   vpw_pkg::vec_type     vec_ff;

   // stage 1: sixteen rounded products
   always_comb begin
      logic signed [63:0] prod;
      logic signed [63:0] rnd;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            prod = $signed(vec_in[c]) * $signed(mat[c*4+r]);
            rnd  = prod + HALF;
            term_in[c*4+r] = TW'(rnd >>> FRAC_BITS);
         end
      end
   end

   // stage 2: row sums, saturated to 32 bits
   always_comb begin
      logic signed [AW-1:0] acc;
      for (int r = 0; r < 4; r++) begin
         acc = AW'(term_ff[r]) + AW'(term_ff[4+r]) + AW'(term_ff[8+r]) + AW'(term_ff[12+r]);
         if (acc > SMAX) begin
            sum_in[r] = 32'h7fff_ffff;
         end else if (acc < SMIN) begin
            sum_in[r] = 32'h8000_0000;
         end else begin
            sum_in[r] = acc[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         term_ff <= term_in;
         vec_ff  <= sum_in;
      end
   end

   assign vec_out = vec_ff;

endmodule

[sv/vpw_div.sv]
module vpw_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic [vpw_pkg::LANES-1:0][FRAC_BITS+33:0] num_in,
   input  logic [32:0]                            den_in,
   input  vpw_pkg::side_type                      side_in,
   output logic [vpw_pkg::LANES-1:0][FRAC_BITS+33:0] quo_out,
   output vpw_pkg::side_type                      side_out
);

   localparam int NW = FRAC_BITS + 34;
   localparam int DW = 33;
   localparam int L  = vpw_pkg::LANES;

   // restoring division, one quotient bit per stage, lanes share the divisor
   logic [DW:0]   a_src [NW][L];
   logic [NW-1:0] q_src [NW][L];
   logic [DW-1:0] d_src [NW];
   vpw_pkg::side_type s_src [NW];

   logic [DW:0]   a_in [NW][L];
   logic [NW-1:0] q_in [NW][L];
   logic [DW:0]   a_ff [NW][L];
   logic [NW-1:0] q_ff [NW][L];
   logic [DW-1:0] d_ff [NW];
   vpw_pkg::side_type s_ff [NW];

   for (genvar s = 0; s < NW; s++) begin : g_src
      if (s == 0) begin : g_first
         for (genvar l = 0; l < L; l++) begin : g_lane
            assign a_src[s][l] = '0;
            assign q_src[s][l] = num_in[l];
         end
         assign d_src[s] = den_in;
         assign s_src[s] = side_in;
      end else begin : g_next
         for (genvar l = 0; l < L; l++) begin : g_lane
            assign a_src[s][l] = a_ff[s-1][l];
            assign q_src[s][l] = q_ff[s-1][l];
         end
         assign d_src[s] = d_ff[s-1];
         assign s_src[s] = s_ff[s-1];
      end
   end

   always_comb begin
      logic [DW:0] sh;
      for (int s = 0; s < NW; s++) begin
         for (int l = 0; l < L; l++) begin
            sh = {a_src[s][l][DW-1:0], q_src[s][l][NW-1]};
            if (sh >= {1'b0, d_src[s]}) begin
               a_in[s][l] = sh - {1'b0, d_src[s]};
               q_in[s][l] = {q_src[s][l][NW-2:0], 1'b1};
            end else begin
               a_in[s][l] = sh;
               q_in[s][l] = {q_src[s][l][NW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_in;
         q_ff <= q_in;
         d_ff <= d_src;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NW; s++) begin
            s_ff[s] <= '0;
         end
      end else if (en) begin
         s_ff <= s_src;
      end
   end

   for (genvar l = 0; l < L; l++) begin : g_out
      assign quo_out[l] = q_ff[NW-1][l];
   end
   assign side_out = s_ff[NW-1];

endmodule

[sv/vertex_projection_to_window_core.sv]
// Channel | Dir | Signals                    | Transfer carries
// req     | in  | req_tvalid/tready/tdata    | cmd, elem_index, coef_value, obj_x/y/z
// rsp     | out | rsp_tvalid/tready/tdata/tuser | win_x, win_y, win_z, projected_ok
// csr     | in  | csr_wr_en/addr/wdata       | viewport registers, no read-back
//
// One item per clock sustained while the output register is free or being drained.
// A project item passes both matrix transforms, the divider prep, the divider with
// FRAC_BITS + 34 quotient bits (50 at Q16.16), the unit map, viewport multiply and
// output register. The whole pipeline advances together, so a stall loses and
// repeats nothing.
// Reset (synchronous) loads identity into both matrices and zeroes the viewport.
module vertex_projection_to_window_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [1:0] cmd, [5:2] elem_index, [37:6] coef_value, [69:38] obj_x,
   // [101:70] obj_y, [133:102] obj_z, [135:134] zero
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] win_x, [63:32] win_y, [95:64] win_z
   output logic [95:0]  rsp_tdata,
   // [0] projected_ok
   output logic         rsp_tuser,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);

   localparam int NW  = FRAC_BITS + 34;     // divider numerator/quotient width
   localparam int HW  = NW + 1;             // unit-mapped value width
   localparam int EW  = (HW > 49) ? HW : 49;
   localparam int L   = vpw_pkg::LANES;
   localparam logic [31:0] ONE_W = 32'(64'd1 << FRAC_BITS);
   localparam logic [NW+1:0] ONE_P1 = (NW+2)'((64'd1 << FRAC_BITS) + 64'd1);
   localparam logic signed [EW-1:0] HLIM_P = EW'(64'sd1 <<< 47);
   localparam logic signed [EW-1:0] HLIM_N = EW'(-(64'sd1 <<< 47));
   localparam logic signed [HW-1:0] ZMAX = HW'(64'sd2147483647);
   localparam logic signed [HW-1:0] ZMIN = HW'(-64'sd2147483648);
   localparam logic signed [65:0] VMAX = 66'(64'sd2147483647);
   localparam logic signed [65:0] VMIN = 66'(-64'sd2147483648);

   typedef struct packed {
      logic        vld;
      logic        ld;      // projection element load
      logic [3:0]  idx;
      logic [31:0] coef;
   } ptag_type;

   // pipeline advances as a whole
   logic en;
   logic acc;
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign acc = req_tvalid && en;

   vpw_pkg::cmd_type req_cmd;
   logic [3:0]  req_idx;
   logic [31:0] req_coef;
   assign req_cmd  = vpw_pkg::cmd_type'(req_tdata[1:0]);
   assign req_idx  = req_tdata[5:2];
   assign req_coef = req_tdata[37:6];

   // viewport registers
   logic signed [15:0] vp_x_ff, vp_y_ff;
   logic [14:0] vp_w_ff, vp_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_x_ff <= '0;
         vp_y_ff <= '0;
         vp_w_ff <= '0;
         vp_h_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            vpw_pkg::REG_VP_X:      vp_x_ff <= csr_wdata;
            vpw_pkg::REG_VP_Y:      vp_y_ff <= csr_wdata;
            vpw_pkg::REG_VP_WIDTH:  vp_w_ff <= csr_wdata[14:0];
            vpw_pkg::REG_VP_HEIGHT: vp_h_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // matrices; model is written on transfer, projection when the load
   // reaches the second transform so older points still see the old value
   vpw_pkg::mat_type model_ff, proj_ff;
   ptag_type t1_in, t1_ff, t2_ff;

   assign t1_in.vld  = acc && (req_cmd == vpw_pkg::CMD_PROJECT ||
                               req_cmd == vpw_pkg::CMD_LOAD_PROJ);
   assign t1_in.ld   = (req_cmd == vpw_pkg::CMD_LOAD_PROJ);
   assign t1_in.idx  = req_idx;
   assign t1_in.coef = req_coef;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            model_ff[i] <= (i % 5 == 0) ? ONE_W : '0;
            proj_ff[i]  <= (i % 5 == 0) ? ONE_W : '0;
         end
      end else begin
         if (acc && req_cmd == vpw_pkg::CMD_LOAD_MODEL) begin
            model_ff[req_idx] <= req_coef;
         end
         if (en && t2_ff.vld && t2_ff.ld) begin
            proj_ff[t2_ff.idx] <= t2_ff.coef;
         end
      end
   end

   // object to eye to clip
   vpw_pkg::vec_type obj_vec, eye_vec, clip_vec;
   assign obj_vec[0] = req_tdata[69:38];
   assign obj_vec[1] = req_tdata[101:70];
   assign obj_vec[2] = req_tdata[133:102];
   assign obj_vec[3] = ONE_W;

   vpw_xform #(.FRAC_BITS(FRAC_BITS)) u_model (
      .clock(clock), .en(en), .vec_in(obj_vec), .mat(model_ff), .vec_out(eye_vec)
   );

   vpw_xform #(.FRAC_BITS(FRAC_BITS)) u_proj (
      .clock(clock), .en(en), .vec_in(eye_vec), .mat(proj_ff), .vec_out(clip_vec)
   );

   logic t3_vld_ff, t4_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff     <= '0;
         t2_ff     <= '0;
         t3_vld_ff <= 1'b0;
         t4_vld_ff <= 1'b0;
      end else if (en) begin
         t1_ff     <= t1_in;
         t2_ff     <= t1_ff;
         t3_vld_ff <= t2_ff.vld && !t2_ff.ld;
         t4_vld_ff <= t3_vld_ff;
      end
   end

   // divider prep: magnitudes, rounding bias folded into the numerator
   logic [L-1:0][NW-1:0] num_in, num_ff;
   logic [32:0] den_in, den_ff;
   vpw_pkg::side_type p_side_in, p_side_ff;
   logic [31:0] uw;

   always_comb begin
      logic [31:0] uc;
      uw = clip_vec[3][31] ? (32'd0 - clip_vec[3]) : clip_vec[3];
      for (int l = 0; l < L; l++) begin
         uc = clip_vec[l][31] ? (32'd0 - clip_vec[l]) : clip_vec[l];
         num_in[l] = (NW'(uc) << (FRAC_BITS + 1)) + NW'(uw);
         p_side_in.neg[l] = clip_vec[l][31] ^ clip_vec[3][31];
      end
      den_in = {uw, 1'b0};
      p_side_in.vld = t4_vld_ff;
      p_side_in.zero_w = (clip_vec[3] == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_side_ff <= '0;
      end else if (en) begin
         p_side_ff <= p_side_in;
      end
   end

   logic [L-1:0][NW-1:0] quo;
   vpw_pkg::side_type d_side;

   vpw_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .en(en),
      .num_in(num_ff), .den_in(den_ff), .side_in(p_side_ff),
      .quo_out(quo), .side_out(d_side)
   );

   // map to 0..1: h = floor((ndc + 1.0 + 1 lsb) / 2)
   logic signed [HW-1:0] h_in [L];
   logic signed [HW-1:0] h_ff [L];
   vpw_pkg::side_type h_side_ff;

   always_comb begin
      logic [NW+1:0] hs;
      for (int l = 0; l < L; l++) begin
         if (d_side.neg[l]) begin
            hs = ONE_P1 - (NW+2)'(quo[l]);
         end else begin
            hs = ONE_P1 + (NW+2)'(quo[l]);
         end
         h_in[l] = $signed(hs[NW+1:1]);
      end
   end

   // x and y clamp, viewport multiply and depth saturation
   logic signed [64:0] mx_in, my_in, mx_ff, my_ff;
   logic [31:0] hz_in, hz_ff;
   vpw_pkg::side_type m_side_ff;

   always_comb begin
      logic signed [EW-1:0] ex, ey;
      logic signed [48:0]   cx, cy;
      ex = EW'(h_ff[0]);
      ey = EW'(h_ff[1]);
      cx = (ex > HLIM_P) ? HLIM_P[48:0] : (ex < HLIM_N) ? HLIM_N[48:0] : ex[48:0];
      cy = (ey > HLIM_P) ? HLIM_P[48:0] : (ey < HLIM_N) ? HLIM_N[48:0] : ey[48:0];
      mx_in = cx * $signed({1'b0, vp_w_ff});
      my_in = cy * $signed({1'b0, vp_h_ff});
      if (h_ff[2] > ZMAX) begin
         hz_in = 32'h7fff_ffff;
      end else if (h_ff[2] < ZMIN) begin
         hz_in = 32'h8000_0000;
      end else begin
         hz_in = h_ff[2][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_ff  <= h_in;
         mx_ff <= mx_in;
         my_ff <= my_in;
         hz_ff <= hz_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_side_ff <= '0;
         m_side_ff <= '0;
      end else if (en) begin
         h_side_ff <= d_side;
         m_side_ff <= h_side_ff;
      end
   end

   // origin offset, saturation, output register
   logic [31:0] wx_in, wy_in;

   always_comb begin
      logic signed [65:0] sx, sy;
      sx = 66'(mx_ff) + (66'(vp_x_ff) <<< FRAC_BITS);
      sy = 66'(my_ff) + (66'(vp_y_ff) <<< FRAC_BITS);
      wx_in = (sx > VMAX) ? 32'h7fff_ffff : (sx < VMIN) ? 32'h8000_0000 : sx[31:0];
      wy_in = (sy > VMAX) ? 32'h7fff_ffff : (sy < VMIN) ? 32'h8000_0000 : sy[31:0];
   end

   logic        rsp_tvalid_ff;
   logic [95:0] rsp_tdata_ff;
   logic        rsp_tuser_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= m_side_ff.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (m_side_ff.zero_w) begin
            rsp_tdata_ff <= '0;
            rsp_tuser_ff <= 1'b0;
         end else begin
            rsp_tdata_ff <= {hz_ff, wy_in, wx_in};
            rsp_tuser_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`ifndef ASSERT_OFF
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("failed projection carries nonzero coordinates");

   a_model_load: assert property (@(posedge clock) disable iff (reset)
      acc && req_cmd == vpw_pkg::CMD_LOAD_MODEL |=>
         model_ff[$past(req_idx)] == $past(req_coef))
      else $error("model element not written");

   a_proj_load: assert property (@(posedge clock) disable iff (reset)
      en && t2_ff.vld && t2_ff.ld |=> proj_ff[$past(t2_ff.idx)] == $past(t2_ff.coef))
      else $error("projection element not written");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(t2_ff) && $stable(m_side_ff))
      else $error("pipeline moved during stall");
`endif

endmodule

[tb/vpw_checker.sv]
module vpw_checker #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [135:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [95:0]  rsp_tdata,
   input  logic         rsp_tuser,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_addr,
   input  logic [15:0]  csr_wdata,
   output int           fail_count,
   output int           points_pending
);

   localparam longint ONE_Q  = longint'(1) << FRAC_BITS;
   localparam longint HALF_Q = longint'(1) << (FRAC_BITS - 1);
   localparam longint S32_HI = 64'sd2147483647;
   localparam longint S32_LO = -64'sd2147483648;
   localparam longint H_LIM  = longint'(1) << 47;

   typedef struct packed {
      logic [31:0] win_x;
      logic [31:0] win_y;
      logic [31:0] win_z;
      logic        ok;
   } window_pt;

   window_pt expected_pts[$];
   longint   model_m[16];
   longint   proj_m[16];
   longint   view_x, view_y, view_w, view_h;

   function automatic longint sat32(input longint v);
      if (v < S32_LO) return S32_LO;
      if (v > S32_HI) return S32_HI;
      return v;
   endfunction

   // rounded Q product; arithmetic shift is a floor
   function automatic longint qmul(input longint a, input longint b);
      return (a * b + HALF_Q) >>> FRAC_BITS;
   endfunction

   function automatic longint qdiv(input longint c, input longint w);
      longint unsigned uc, uw, q;
      uc = (c < 0) ? longint'(-c) : c;
      uw = (w < 0) ? longint'(-w) : w;
      q  = (2 * (uc << FRAC_BITS) + uw) / (2 * uw);
      return ((c < 0) != (w < 0)) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint scale_to_view(input longint h, input longint size,
                                            input longint origin);
      if (h > H_LIM) h = H_LIM;
      if (h < -H_LIM) h = -H_LIM;
      return sat32(h * size + origin * ONE_Q);
   endfunction

   function automatic window_pt project_point(input logic [31:0] ox, input logic [31:0] oy,
                                              input logic [31:0] oz);
      longint   obj[4], eye[4], clip[4], acc, h[3];
      window_pt p;
      obj[0] = longint'($signed(ox));
      obj[1] = longint'($signed(oy));
      obj[2] = longint'($signed(oz));
      obj[3] = ONE_Q;
      for (int r = 0; r < 4; r++) begin
         acc = 0;
         for (int c = 0; c < 4; c++) acc += qmul(obj[c], model_m[c*4+r]);
         eye[r] = sat32(acc);
      end
      for (int r = 0; r < 4; r++) begin
         acc = 0;
         for (int c = 0; c < 4; c++) acc += qmul(eye[c], proj_m[c*4+r]);
         clip[r] = sat32(acc);
      end
      if (clip[3] == 0) begin
         p = '{32'd0, 32'd0, 32'd0, 1'b0};
         return p;
      end
      // map ndc to 0..1 with round half up
      for (int i = 0; i < 3; i++) h[i] = (qdiv(clip[i], clip[3]) + ONE_Q + 1) >>> 1;
      p.win_x = 32'(scale_to_view(h[0], view_w, view_x));
      p.win_y = 32'(scale_to_view(h[1], view_h, view_y));
      p.win_z = 32'(sat32(h[2]));
      p.ok    = 1'b1;
      return p;
   endfunction

   assign points_pending = expected_pts.size();

   always @(posedge clock) begin
      window_pt got, want;
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            model_m[i] = (i % 5 == 0) ? ONE_Q : 0;
            proj_m[i]  = (i % 5 == 0) ? ONE_Q : 0;
         end
         view_x = 0; view_y = 0; view_w = 0; view_h = 0;
         expected_pts.delete();
         fail_count <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_addr)
               vpw_pkg::REG_VP_X:      view_x = longint'($signed(csr_wdata));
               vpw_pkg::REG_VP_Y:      view_y = longint'($signed(csr_wdata));
               vpw_pkg::REG_VP_WIDTH:  view_w = longint'(csr_wdata[14:0]);
               vpw_pkg::REG_VP_HEIGHT: view_h = longint'(csr_wdata[14:0]);
            endcase
         end
         if (req_tvalid && req_tready) begin
            case (req_tdata[1:0])
               vpw_pkg::CMD_LOAD_MODEL:
                  model_m[req_tdata[5:2]] = longint'($signed(req_tdata[37:6]));
               vpw_pkg::CMD_LOAD_PROJ:
                  proj_m[req_tdata[5:2]]  = longint'($signed(req_tdata[37:6]));
               vpw_pkg::CMD_PROJECT:
                  expected_pts.push_back(project_point(req_tdata[69:38],
                                         req_tdata[101:70], req_tdata[133:102]));
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tuser};
            if (expected_pts.size() == 0) begin
               $display("%0t: unexpected transfer x=%h y=%h z=%h ok=%b", $time,
                        got.win_x, got.win_y, got.win_z, got.ok);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_pts.pop_front();
               if (got != want) begin
                  $display("%0t: mismatch exp x=%h y=%h z=%h ok=%b got x=%h y=%h z=%h ok=%b",
                           $time, want.win_x, want.win_y, want.win_z, want.ok,
                           got.win_x, got.win_y, got.win_z, got.ok);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

[tb/tb_vertex_projection_to_window_core.sv]
module tb_vertex_projection_to_window_core;

   localparam int  DRAIN_CYCLES = 80;       // covers the pipeline depth at Q16.16
   localparam int  CYCLE_LIMIT  = 600000;
   localparam int  HOLD_CYCLES  = 300;      // long receiver hold-off
   localparam logic [31:0] Q_ONE = 32'h0001_0000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // [1:0] cmd, [5:2] elem_index, [37:6] coef_value, [69:38] obj_x,
   // [101:70] obj_y, [133:102] obj_z, [135:134] zero
   logic [135:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // [31:0] win_x, [63:32] win_y, [95:64] win_z
   logic [95:0]  rsp_tdata;
   // [0] projected_ok
   logic         rsp_tuser;
   logic         csr_wr_en;
   logic [1:0]   csr_addr;
   logic [15:0]  csr_wdata;

   int fail_count;
   int points_pending;
   int sender_idle_pct;
   int recv_stall_pct;
   int cycle_count = 0;
   bit hold_req;
   int hold_cnt;

   vertex_projection_to_window_core dut (.*);

   vpw_checker chk (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_wr_en, .csr_addr, .csr_wdata,
      .fail_count, .points_pending
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, plus one long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_cnt   <= 0;
      end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
         rsp_tready <= 1'b0;
         hold_cnt   <= hold_cnt + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [135:0] pack_item(input vpw_pkg::cmd_type cmd,
                                              input logic [3:0] idx,
                                              input logic [31:0] coef, input logic [31:0] x,
                                              input logic [31:0] y, input logic [31:0] z);
      return {2'b00, z, y, x, coef, idx, cmd};
   endfunction

   // one transfer on the request side, with random sender gaps first
   task automatic send_raw(input logic [135:0] d);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic load_elem(input vpw_pkg::cmd_type cmd, input int idx, input logic [31:0] v);
      send_raw(pack_item(cmd, idx[3:0], v, $urandom, $urandom, $urandom));
   endtask

   task automatic project(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
      send_raw(pack_item(vpw_pkg::CMD_PROJECT, 4'($urandom), $urandom, x, y, z));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (points_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_viewport(input logic [15:0] vx, input logic [15:0] vy,
                               input logic [15:0] vw, input logic [15:0] vh);
      logic [15:0] vals[4];
      vals = '{vx, vy, vw, vh};
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_addr  <= i[1:0];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // small Q16.16 value, roughly +-4.0
   function automatic logic [31:0] modest_coef();
      return $urandom_range(32'h0008_0000) - 32'h0004_0000;
   endfunction

   task automatic random_item();
      int roll;
      roll = $urandom_range(99);
      if (roll < 12) begin
         load_elem(($urandom_range(1) != 0) ? vpw_pkg::CMD_LOAD_PROJ : vpw_pkg::CMD_LOAD_MODEL,
                   $urandom_range(15), ($urandom_range(5) == 0) ? $urandom : modest_coef());
      end else if (roll < 15) begin
         // unused command code, ignored by the block
         send_raw({2'b00, 32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
                   4'($urandom), 2'd3});
      end else if (roll < 30) begin
         project($urandom, $urandom, $urandom);
      end else begin
         project($urandom_range(32'h0040_0000) - 32'h0020_0000,
                 $urandom_range(32'h0040_0000) - 32'h0020_0000,
                 $urandom_range(32'h0040_0000) - 32'h0020_0000);
      end
   endtask

   // perspective-like setup: model is a random affine map, proj weights eye w into clip w by 1.0 to 3.0
   task automatic random_matrices();
      for (int i = 0; i < 16; i++)
         load_elem(vpw_pkg::CMD_LOAD_MODEL, i,
                   (i % 4 == 3) ? ((i == 15) ? Q_ONE : 32'd0) : modest_coef());
      for (int i = 0; i < 16; i++)
         load_elem(vpw_pkg::CMD_LOAD_PROJ, i,
                   (i == 15) ? Q_ONE + $urandom_range(32'h0002_0000) : modest_coef());
   endtask

   initial begin
      int idle_sets[5][2];
      idle_sets = '{'{0, 0}, '{76, 0}, '{0, 76}, '{26, 26}, '{0, 0}};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_addr = vpw_pkg::REG_VP_X;
      csr_wdata = '0;
      sender_idle_pct = 0;
      recv_stall_pct = 0;
      hold_req = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identity matrices, extreme viewport
      set_viewport(16'h8000, 16'h7fff, 16'hffff, 16'h0000);
      project(32'd0, 32'd0, 32'd0);
      project(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      project(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      project(32'hffff_ffff, 32'h0000_0001, Q_ONE);
      send_raw(pack_item(vpw_pkg::CMD_PROJECT, 4'hf, 32'hffff_ffff, Q_ONE, Q_ONE, Q_ONE));
      send_raw({2'b00, 128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff, 4'hf, 2'd3});
      // zero clip w
      load_elem(vpw_pkg::CMD_LOAD_PROJ, 15, 32'd0);
      project(Q_ONE, Q_ONE, Q_ONE);
      // negative w and huge coefficients
      load_elem(vpw_pkg::CMD_LOAD_PROJ, 15, 32'hffff_0000);
      load_elem(vpw_pkg::CMD_LOAD_MODEL, 0, 32'h7fff_ffff);
      load_elem(vpw_pkg::CMD_LOAD_MODEL, 5, 32'h8000_0000);
      load_elem(vpw_pkg::CMD_LOAD_PROJ, 11, 32'h0000_8000);
      project(32'h0002_0000, 32'hfffe_0000, 32'h0003_0000);
      project(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      // tiny w drives the quotient far out
      load_elem(vpw_pkg::CMD_LOAD_PROJ, 15, 32'd1);
      load_elem(vpw_pkg::CMD_LOAD_PROJ, 11, 32'd0);
      project(32'h7fff_0000, 32'h8000_0000, 32'h0000_0001);
      wait_idle();

      for (int ph = 0; ph < 5; ph++) begin
         sender_idle_pct = idle_sets[ph][0];
         recv_stall_pct  = idle_sets[ph][1];
         case (ph)
            0: set_viewport(16'h0000, 16'h0000, 16'd640, 16'd480);
            1: set_viewport(16'h7fff, 16'h8000, 16'h0000, 16'h7fff);
            4: set_viewport(16'h0000, 16'h0000, 16'h0000, 16'h0000);
            default: set_viewport(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom));
         endcase
         random_matrices();
         for (int n = 0; n < 180; n++) begin
            if (ph == 4 && n == 20) hold_req = 1'b1;
            if (ph == 1 && n == 135) begin
               // let everything drain before going on
               req_tvalid <= 1'b0;
               @(posedge clock);
               while (points_pending != 0) @(posedge clock);
            end
            if (n % 90 == 89) random_matrices();
            random_item();
         end
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
